// ===== design/page_table_walk_defines.svh =====
// Assertion macros for the page table walker, used by ptw_ctrl.
// Each macro expects clk and rst (synchronous, active high) in the using scope.
`ifndef PAGE_TABLE_WALK_DEFINES_SVH
`define PAGE_TABLE_WALK_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define PTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define PTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ptw_pkg.sv =====
// Shared constants, types and control encodings for the page table walker.
// No dependencies; imported by every module of the block except ptw_ram.
`timescale 1ns / 1ps

package ptw_pkg;

  // Store geometry
  localparam int TABLE_PAGES = 8;
  localparam int VPN_W       = 9;
  localparam int ENTRIES     = 1 << VPN_W;
  localparam int STORE_DEPTH = TABLE_PAGES * ENTRIES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths
  localparam int PPN_W   = 44;
  localparam int VA_W    = 39;
  localparam int PA_W    = 56;
  localparam int ENTRY_W = 64;
  localparam int IDX_W   = 12;
  localparam int LEVEL_W = 2;
  localparam int CFG_W   = 44;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_PAGE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 1'd1;

  // Request types
  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_WRITE     = 1'b1;

  // Walk levels
  localparam logic [LEVEL_W-1:0] LEVEL_TOP = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_MID = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_BOT = 2'd0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_WDONE,
    ST_FAULT
  } ptw_state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;
    logic wr_en;
    logic sel_root;
    logic rd_root;
    logic rd_next;
    logic load_leaf;
    logic load_fault;
    logic load_zero;
  } ptw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic               clear_last;
    logic               page_ok;
    logic               entry_valid;
    logic               entry_leaf;
    logic [LEVEL_W-1:0] level;
  } ptw_sts_t;

endpackage

// ===== design/page_table_walk.sv =====
// Three-level page table walker over an internal entry store of TABLE_PAGES
// tables of 512 entries each. After reset the store is swept to zero entry by
// entry while in_stall is held high; config writes are taken during the sweep.
// A write request loads its result register once the output is free. A translate
// request makes one store read per level, each through the store's registered
// read port; the walk ends after one, two or three entry reads (a root table
// outside the region ends after one). The next request is accepted in the cycle
// after the result is loaded. A held output does not block a walk until its
// result is due.
// Depends on ptw_pkg, ptw_ctrl, ptw_dp and ptw_ram.
`timescale 1ns / 1ps

module page_table_walk
  import ptw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 req_type,
  input  logic [VA_W-1:0]      virt_addr,
  input  logic [IDX_W-1:0]     entry_index,
  input  logic [ENTRY_W-1:0]   entry_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PA_W-1:0]      phys_addr,
  output logic                 fault,
  output logic [LEVEL_W-1:0]   leaf_level
);

  ptw_cmd_t cmd;
  ptw_sts_t sts;

  ptw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptw_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .virt_addr   (virt_addr),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .cmd         (cmd),
    .sts         (sts),
    .phys_addr   (phys_addr),
    .fault       (fault),
    .leaf_level  (leaf_level)
  );

endmodule

// ===== design/ptw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/ptw_dp.sv =====
// Walker datapath: config registers, entry store, address/range check, result regs.
// Depends on ptw_pkg and ptw_ram.
`timescale 1ns / 1ps

module ptw_dp
  import ptw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [VA_W-1:0]      virt_addr,
  input  logic [IDX_W-1:0]     entry_index,
  input  logic [ENTRY_W-1:0]   entry_value,
  input  ptw_cmd_t             cmd,
  output ptw_sts_t             sts,
  output logic [PA_W-1:0]      phys_addr,
  output logic                 fault,
  output logic [LEVEL_W-1:0]   leaf_level
);

  logic [PPN_W-1:0]   root_page_number;
  logic [PPN_W-1:0]   region_base_page;
  logic [VA_W-1:0]    va;
  logic [LEVEL_W-1:0] level;
  logic [ADDR_W-1:0]  clear_cnt;
  logic [ENTRY_W-1:0] rdata;

  logic [PPN_W-1:0]   page;
  logic [PPN_W-1:0]   diff;
  logic [VPN_W-1:0]   vpn;
  logic [ADDR_W-1:0]  raddr;
  logic [ADDR_W-1:0]  waddr;
  logic [ENTRY_W-1:0] wdata;
  logic               we;
  logic               wr_in_range;
  logic [PA_W-1:0]    leaf_pa;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      root_page_number <= '0;
      region_base_page <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROOT_PAGE:   root_page_number <= cfg_wdata;
        REG_REGION_BASE: region_base_page <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt <= '0;
    end else if (cmd.clr_en) begin
      clear_cnt <= clear_cnt + 1'b1;
    end
  end

  // Walk context: address under translation and level of the pending read
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= LEVEL_TOP;
    end else if (cmd.rd_root) begin
      level <= LEVEL_TOP;
    end else if (cmd.rd_next) begin
      level <= level - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_root) begin
      va <= virt_addr;
    end
  end

  // Table page to store address, with region check
  always_comb begin
    page = cmd.sel_root ? root_page_number : rdata[53:10];
    diff = page - region_base_page;
    if (cmd.sel_root) begin
      vpn = virt_addr[38:30];
    end else if (level == LEVEL_TOP) begin
      vpn = va[29:21];
    end else begin
      vpn = va[20:12];
    end
    raddr = ADDR_W'({diff, vpn});
  end

  // Store write port: clearing sweep or entry write
  assign wr_in_range = (32'(entry_index) < 32'(STORE_DEPTH));
  assign we    = cmd.clr_en | (cmd.wr_en & wr_in_range);
  assign waddr = cmd.clr_en ? clear_cnt : ADDR_W'(entry_index);
  assign wdata = cmd.clr_en ? '0 : entry_value;

  ptw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_root | cmd.rd_next),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Status back to the controller
  always_comb begin
    sts.clear_last  = (clear_cnt == ADDR_W'(STORE_DEPTH - 1));
    sts.page_ok     = (page >= region_base_page) && (diff < PPN_W'(TABLE_PAGES));
    sts.entry_valid = rdata[0];
    sts.entry_leaf  = |rdata[3:1];
    sts.level       = level;
  end

  // Leaf address: superpages keep the low VA bits
  always_comb begin
    case (level)
      LEVEL_TOP: leaf_pa = {rdata[53:28], va[29:0]};
      LEVEL_MID: leaf_pa = {rdata[53:19], va[20:0]};
      default:   leaf_pa = {rdata[53:10], va[11:0]};
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_leaf) begin
      phys_addr  <= leaf_pa;
      fault      <= 1'b0;
      leaf_level <= level;
    end else if (cmd.load_fault) begin
      phys_addr  <= '0;
      fault      <= 1'b1;
      leaf_level <= '0;
    end else if (cmd.load_zero) begin
      phys_addr  <= '0;
      fault      <= 1'b0;
      leaf_level <= '0;
    end
  end

endmodule

// ===== design/ptw_ctrl.sv =====
// Walker controller: clearing sweep, request intake, per-level walk decisions.
// Depends on ptw_pkg and page_table_walk_defines.svh.
`timescale 1ns / 1ps
`include "page_table_walk_defines.svh"

module ptw_ctrl
  import ptw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     req_type,
  output logic     out_valid,
  input  logic     out_stall,
  input  ptw_sts_t sts,
  output ptw_cmd_t cmd
);

  ptw_state_t state;
  ptw_state_t state_next;
  logic       out_free;
  logic       load;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign load     = cmd.load_leaf | cmd.load_fault | cmd.load_zero;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.sel_root = (state == ST_IDLE);
    case (state)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_WRITE) begin
            cmd.wr_en  = 1'b1;
            state_next = ST_WDONE;
          end else begin
            cmd.rd_root = 1'b1;
            state_next  = sts.page_ok ? ST_WALK : ST_FAULT;
          end
        end
      end
      ST_WALK: begin
        // entry of the current level is on the store read port
        if (!sts.entry_valid) begin
          if (out_free) begin
            cmd.load_fault = 1'b1;
            state_next     = ST_IDLE;
          end
        end else if (sts.entry_leaf) begin
          if (out_free) begin
            cmd.load_leaf = 1'b1;
            state_next    = ST_IDLE;
          end
        end else if (sts.level == LEVEL_BOT || !sts.page_ok) begin
          if (out_free) begin
            cmd.load_fault = 1'b1;
            state_next     = ST_IDLE;
          end
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      ST_WDONE: begin
        if (out_free) begin
          cmd.load_zero = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_FAULT: begin
        if (out_free) begin
          cmd.load_fault = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Checks
  `PTW_ASSERT(a_one_result_kind, $onehot0({cmd.load_leaf, cmd.load_fault, cmd.load_zero}), "more than one result kind loaded")
  `PTW_ASSERT(a_no_descent_past_bottom, !cmd.rd_next || sts.level != LEVEL_BOT, "walk descended below the last level")
  `PTW_ASSERT(a_load_needs_room, !load || out_free, "result loaded over a held result")
  `PTW_ASSERT_NEXT(a_walk_holds_read, state == ST_WALK && !cmd.rd_next && !load, state == ST_WALK && $stable(sts.entry_valid) && $stable(sts.level), "walk lost its pending entry while waiting")

endmodule
